// ===== src/tcw_pkg.sv =====
// tcw_pkg: shared types and constants of the text console writer.
// No dependencies; imported by tcw_core and text_console_writer.
`default_nettype none

package tcw_pkg;

  // Default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // Cell and character constants
  localparam logic [7:0] ATTR_RESET = 8'h09;
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam int         TAB_STOP   = 4;
  localparam int         TAB_BITS   = $clog2(TAB_STOP);
  localparam int         CELL_W     = 16;

  // Function codes; code 3 is unused and only reports the cursor
  localparam logic [1:0] FUNC_PUT   = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  char_code;
    logic [10:0] read_address;
  } item_t;

  typedef struct packed {
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic [15:0] read_data;
  } result_t;

  typedef enum logic [3:0] {
    S_INIT_FILL,
    S_IDLE,
    S_CLEAR_FILL,
    S_SCROLL_COPY,
    S_SCROLL_DRAIN,
    S_SCROLL_BLANK,
    S_WRITE_CHAR,
    S_WRITE_TAB,
    S_READ_ISSUE,
    S_READ_CAPTURE
  } state_t;

  // What a put does once a scroll has finished
  typedef enum logic [1:0] {
    AFTER_NONE,
    AFTER_CHAR,
    AFTER_TAB
  } after_t;

endpackage

`default_nettype wire

// ===== src/tcw_ram.sv =====
// tcw_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/tcw_core.sv =====
// tcw_core: sequencer, cursor and sweep counter of the text console writer.
// Depends on tcw_pkg; drives the write and read ports of one tcw_ram.
`default_nettype none

module tcw_core #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF,
  localparam int CELLS  = COLUMNS * ROWS,
  localparam int AW     = $clog2(CELLS),
  localparam int RW     = $clog2(ROWS),
  localparam int CW     = $clog2(COLUMNS + 1)
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire tcw_pkg::item_t          item,
  input  wire logic [7:0]              attr,
  output logic                         done,
  output tcw_pkg::result_t             result,
  output logic                         ram_we,
  output logic [AW-1:0]                ram_waddr,
  output logic [tcw_pkg::CELL_W-1:0]   ram_wdata,
  output logic [AW-1:0]                ram_raddr,
  input  wire logic [tcw_pkg::CELL_W-1:0] ram_rdata
);

  import tcw_pkg::*;

  state_t              state, state_next;
  logic [RW-1:0]       row, row_next;
  logic [CW-1:0]       col, col_next;
  logic [AW-1:0]       sweep, sweep_next;
  logic [AW-1:0]       sweep_d;
  logic                copy_valid;
  logic [7:0]          ch, ch_next;
  after_t              after, after_next;
  logic [CELL_W-1:0]   fill, fill_next;
  logic [AW-1:0]       rd_q, rd_next;
  logic [CELL_W-1:0]   data_next;

  logic                accept;
  logic                fin;
  logic                at_bottom;
  logic                wrap_pend;
  logic                nl;
  logic                ch_skip;
  after_t              kind;
  logic                in_range;
  logic                sweep_last;
  logic                copy_last;
  logic [CW-1:0]       col_inc;
  logic                tab_end;
  logic [AW-1:0]       cell_addr;

  assign busy       = (state != S_IDLE);
  assign accept     = start && (state == S_IDLE);
  assign at_bottom  = (row == RW'(ROWS - 1));
  assign wrap_pend  = (col >= CW'(COLUMNS));
  assign ch_skip    = (item.char_code == CH_NUL) || (item.char_code == CH_CR);
  assign nl         = (item.char_code == CH_LF) || (!ch_skip && wrap_pend);
  assign in_range   = (32'(item.read_address) < 32'(CELLS));
  assign sweep_last = (sweep == AW'(CELLS - 1));
  assign copy_last  = (sweep == AW'(CELLS - COLUMNS - 1));
  assign col_inc    = col + 1'b1;
  assign tab_end    = (col_inc[TAB_BITS-1:0] == '0) || (col_inc >= CW'(COLUMNS));
  assign cell_addr  = AW'(row * COLUMNS) + AW'(col);

  always_comb begin
    if (item.char_code == CH_LF) begin
      kind = AFTER_NONE;
    end else if (item.char_code == CH_TAB) begin
      kind = AFTER_TAB;
    end else begin
      kind = AFTER_CHAR;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (item.func)
            FUNC_PUT: begin
              if (ch_skip) begin
                state_next = S_IDLE;
              end else if (nl && at_bottom) begin
                state_next = S_SCROLL_COPY;
              end else if (kind == AFTER_TAB) begin
                state_next = S_WRITE_TAB;
              end else if (kind == AFTER_CHAR) begin
                state_next = S_WRITE_CHAR;
              end else begin
                state_next = S_IDLE;
              end
            end
            FUNC_CLEAR: state_next = S_CLEAR_FILL;
            FUNC_READ:  state_next = in_range ? S_READ_ISSUE : S_IDLE;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_INIT_FILL, S_CLEAR_FILL: begin
        if (sweep_last) state_next = S_IDLE;
      end
      S_SCROLL_COPY: begin
        if (copy_last) state_next = S_SCROLL_DRAIN;
      end
      S_SCROLL_DRAIN: state_next = S_SCROLL_BLANK;
      S_SCROLL_BLANK: begin
        if (sweep_last) begin
          case (after)
            AFTER_CHAR: state_next = S_WRITE_CHAR;
            AFTER_TAB:  state_next = S_WRITE_TAB;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_WRITE_CHAR: state_next = S_IDLE;
      S_WRITE_TAB: begin
        if (tab_end) state_next = S_IDLE;
      end
      S_READ_ISSUE:   state_next = S_READ_CAPTURE;
      S_READ_CAPTURE: state_next = S_IDLE;
      default:        state_next = S_IDLE;
    endcase
  end

  // Item completes on the edge that returns to idle; the reset fill reports nothing
  assign fin = (state_next == S_IDLE) &&
               (accept || ((state != S_IDLE) && (state != S_INIT_FILL)));

  // Cursor, sweep counter and latched item
  always_comb begin
    row_next   = row;
    col_next   = col;
    sweep_next = sweep;
    ch_next    = ch;
    after_next = after;
    fill_next  = fill;
    rd_next    = rd_q;
    data_next  = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          ch_next    = item.char_code;
          after_next = kind;
          sweep_next = '0;
          fill_next  = {attr, CH_SPACE};
          rd_next    = AW'(item.read_address);
          case (item.func)
            FUNC_PUT: begin
              if (item.char_code == CH_CR) begin
                col_next = '0;
              end else if (nl) begin
                col_next = '0;
                if (!at_bottom) row_next = row + 1'b1;
              end
            end
            FUNC_CLEAR: begin
              row_next = '0;
              col_next = '0;
            end
            default: ;
          endcase
        end
      end
      S_INIT_FILL, S_CLEAR_FILL, S_SCROLL_BLANK: sweep_next = sweep + 1'b1;
      S_SCROLL_COPY: sweep_next = copy_last ? AW'(CELLS - COLUMNS) : sweep + 1'b1;
      S_WRITE_CHAR, S_WRITE_TAB: col_next = col_inc;
      S_READ_CAPTURE: data_next = ram_rdata;
      default: ;
    endcase
  end

  // Memory ports
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cell_addr;
    ram_wdata = fill;
    ram_raddr = rd_q;
    case (state)
      S_INIT_FILL, S_CLEAR_FILL, S_SCROLL_BLANK: begin
        ram_we    = 1'b1;
        ram_waddr = sweep;
      end
      S_SCROLL_COPY, S_SCROLL_DRAIN: begin
        ram_raddr = sweep + AW'(COLUMNS);
        ram_we    = copy_valid;
        ram_waddr = sweep_d;
        ram_wdata = ram_rdata;
      end
      S_WRITE_CHAR: begin
        ram_we    = 1'b1;
        ram_wdata = {fill[CELL_W-1:8], ch};
      end
      S_WRITE_TAB: ram_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT_FILL;
      row        <= '0;
      col        <= '0;
      sweep      <= '0;
      fill       <= {ATTR_RESET, CH_SPACE};
      copy_valid <= 1'b0;
      done       <= 1'b0;
      after      <= AFTER_NONE;
    end else begin
      state      <= state_next;
      row        <= row_next;
      col        <= col_next;
      sweep      <= sweep_next;
      fill       <= fill_next;
      copy_valid <= (state == S_SCROLL_COPY);
      done       <= fin;
      after      <= after_next;
    end
  end

  always_ff @(posedge clk) begin
    sweep_d <= sweep;
    ch      <= ch_next;
    rd_q    <= rd_next;
    if (fin) begin
      result <= {5'(row_next), 7'(col_next), data_next};
    end
  end

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    col <= CW'(COLUMNS)) else $error("cursor column beyond row end");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    row <= RW'(ROWS - 1)) else $error("cursor row beyond screen");

  a_cell_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE_CHAR || state == S_WRITE_TAB) |-> (col < CW'(COLUMNS)))
    else $error("cell write with wrap pending");

  a_copy_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCROLL_COPY && copy_valid) |-> (ram_waddr < ram_raddr))
    else $error("scroll copy overwrites an unread cell");

  a_no_init_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_INIT_FILL) |=> !done) else $error("result during reset fill");

endmodule

`default_nettype wire

// ===== src/text_console_writer.sv =====
// text_console_writer: top level of the character-cell text console.
// Depends on tcw_pkg, tcw_core and tcw_ram.
//
// Usage:
//  - Command channel: an item (func, char_code, read_address) is taken on a
//    rising edge with start high and busy low. busy stays high until the
//    item's result has been produced.
//  - Result channel: done is high for exactly one cycle with the result beat
//    (cursor_row, cursor_col, read_data). The receiver cannot stall it.
//  - Config channel: cfg_valid/cfg_ready/cfg_data write the attribute byte;
//    cfg_ready is always high. Write only while the block is idle.
//  - Sequencing (CELLS = ROWS*COLUMNS, one cell a cycle through the single
//    RAM write port): NUL, CR, LF without scroll, an unused code and an
//    out-of-range read finish without leaving idle; an ordinary character
//    writes one cell; a tab writes cells up to the next tab stop; a read
//    issues then captures; clear and a scroll before a put pass every cell.
//  - Reset: the cursor homes and a clearing pass writes every cell with
//    space and attribute 0x09 (CELLS = 2000 by default), with busy high.
`default_nettype none

module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire tcw_pkg::item_t   item,
  output logic                  done,
  output tcw_pkg::result_t      result,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [7:0]       cfg_data
);

  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  logic [7:0]        attr;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  // Attribute register: always ready, one beat per write
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= ATTR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      attr <= cfg_data;
    end
  end

  tcw_core #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .attr      (attr),
    .done      (done),
    .result    (result),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // Screen store: one cell per entry, attribute high byte
  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire
